FILE: rtl/mwpo_pkg.sv
package mwpo_pkg;

   localparam int PHASE_BITS      = 32;
   localparam int SINE_TABLE_BITS = 8;
   localparam int SAMPLE_BITS     = 16;

   localparam int TUNING_BITS = 32;
   localparam int AMP_BITS    = 15;
   localparam int WAVE_BITS   = 2;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;

   localparam int QTR_LEN = 1 << SINE_TABLE_BITS;
   localparam longint unsigned FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // align tuning word to accumulator width
   localparam int TW_RSH = (TUNING_BITS > PHASE_BITS) ? TUNING_BITS - PHASE_BITS : 0;
   localparam int TW_LSH = (PHASE_BITS > TUNING_BITS) ? PHASE_BITS - TUNING_BITS : 0;
   // triangle slope: d * 2^(SAMPLE_BITS+1) / 2^PHASE_BITS
   localparam int TRI_RSH = (PHASE_BITS > SAMPLE_BITS + 1) ? PHASE_BITS - SAMPLE_BITS - 1 : 0;
   localparam int TRI_LSH = (SAMPLE_BITS + 1 > PHASE_BITS) ? SAMPLE_BITS + 1 - PHASE_BITS : 0;
   // sawtooth: phase * 2^(SAMPLE_BITS-1) / 2^PHASE_BITS
   localparam int SAW_RSH = (PHASE_BITS > SAMPLE_BITS - 1) ? PHASE_BITS - SAMPLE_BITS + 1 : 0;
   localparam int SAW_LSH = (SAMPLE_BITS - 1 > PHASE_BITS) ? SAMPLE_BITS - 1 - PHASE_BITS : 0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TUNING_WORD = 2'd0,
      CSR_AMPLITUDE   = 2'd1,
      CSR_WAVEFORM    = 2'd2
   } csr_index_type;

   typedef enum logic [WAVE_BITS-1:0] {
      WAVE_SINE     = 2'd0,
      WAVE_TRIANGLE = 2'd1,
      WAVE_SQUARE   = 2'd2,
      WAVE_SAWTOOTH = 2'd3
   } wave_sel_type;

   typedef struct packed {
      logic                  valid;
      logic [PHASE_BITS-1:0] phase;
   } stage_type;

   typedef logic [QTR_LEN:0][SAMPLE_BITS-1:0] quarter_type;

   // quarter-wave sine table, Q30 Taylor series then scaled to full scale
   function automatic quarter_type build_quarter();
      quarter_type           tab;
      logic [63:0]           x;
      logic [63:0]           term;
      logic [63:0]           t1;
      logic [63:0]           t2;
      logic signed [63:0]    sum;
      logic [63:0]           rnd;
      tab = '0;
      for (int i = 0; i <= QTR_LEN; i++) begin
         x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         term = x;
         sum  = signed'(x);
         for (int k = 1; k <= 7; k++) begin
            t1 = (term * x) >> 30;
            t2 = (t1 * x) >> 30;
            case (k)
               1: term = t2 / 64'd6;
               2: term = t2 / 64'd20;
               3: term = t2 / 64'd42;
               4: term = t2 / 64'd72;
               5: term = t2 / 64'd110;
               6: term = t2 / 64'd156;
               default: term = t2 / 64'd210;
            endcase
            if ((k % 2) == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = '0;
         end
         rnd = (unsigned'(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
         tab[i] = rnd[SAMPLE_BITS-1:0];
      end
      return tab;
   endfunction

   localparam quarter_type QUARTER = build_quarter();

endpackage

FILE: rtl/mwpo_phase_acc.sv
module mwpo_phase_acc
   import mwpo_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   phase_reset,
   input  logic                   drain,
   input  logic [TUNING_BITS-1:0] tuning_word,
   output stage_type              stage
);

   logic [PHASE_BITS-1:0]             acc_ff;
   logic [PHASE_BITS-1:0]             acc_in;
   logic [PHASE_BITS-1:0]             cur_phase;
   logic [PHASE_BITS-1:0]             step;
   logic [TUNING_BITS+PHASE_BITS-1:0] tw_wide;
   stage_type                         stage_ff;
   stage_type                         stage_in;

   assign tw_wide   = (TUNING_BITS + PHASE_BITS)'(tuning_word);
   assign step      = PHASE_BITS'((tw_wide >> TW_RSH) << TW_LSH);
   assign cur_phase = phase_reset ? '0 : acc_ff;

   always_comb begin
      acc_in   = acc_ff;
      stage_in = stage_ff;
      if (load) begin
         // sample the current phase, then advance
         acc_in         = cur_phase + step;
         stage_in.valid = 1'b1;
         stage_in.phase = cur_phase;
      end else if (drain) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         acc_ff         <= acc_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.phase <= stage_in.phase;
   end

   assign stage = stage_ff;

endmodule

FILE: rtl/mwpo_wave_gen.sv
module mwpo_wave_gen
   import mwpo_pkg::*;
(
   input  logic [PHASE_BITS-1:0]  phase,
   input  logic [WAVE_BITS-1:0]   waveform,
   input  logic [AMP_BITS-1:0]    amplitude,
   output logic [SAMPLE_BITS-1:0] sample
);

   localparam int WIDE_BITS = PHASE_BITS + SAMPLE_BITS + 2;
   localparam logic [SAMPLE_BITS-1:0] FS     = SAMPLE_BITS'(FULL_SCALE);
   localparam logic [SAMPLE_BITS-1:0] FS_MAX = SAMPLE_BITS'(FULL_SCALE - 64'd1);

   logic [1:0]                      quadrant;
   logic [SINE_TABLE_BITS-1:0]      j;
   logic [SINE_TABLE_BITS:0]        idx;
   logic [PHASE_BITS-1:0]           half;
   logic [PHASE_BITS-1:0]           dev;
   logic [WIDE_BITS-1:0]            dist_wide;
   logic [WIDE_BITS-1:0]            phase_wide;
   logic [SAMPLE_BITS:0]            tri_t;
   logic [SAMPLE_BITS:0]            fs_ext;
   logic [SAMPLE_BITS-1:0]          saw_mag;
   logic                            neg;
   logic [SAMPLE_BITS-1:0]          mag;
   logic [SAMPLE_BITS+AMP_BITS-1:0] product;
   logic [SAMPLE_BITS+AMP_BITS:0]   rounded;
   logic [SAMPLE_BITS-1:0]          scaled;
   logic [SAMPLE_BITS-1:0]          pos_sat;

   assign quadrant = phase[PHASE_BITS-1 -: 2];
   assign j        = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign idx      = quadrant[0] ? (SINE_TABLE_BITS+1)'(QTR_LEN) - {1'b0, j} : {1'b0, j};

   assign half       = {1'b1, {(PHASE_BITS-1){1'b0}}};
   assign dev        = (phase >= half) ? phase - half : half - phase;
   assign dist_wide  = WIDE_BITS'(dev);
   assign phase_wide = WIDE_BITS'(phase);
   assign tri_t      = (SAMPLE_BITS+1)'((dist_wide >> TRI_RSH) << TRI_LSH);
   assign fs_ext     = {1'b0, FS};
   assign saw_mag    = SAMPLE_BITS'((phase_wide >> SAW_RSH) << SAW_LSH);

   // waveform as sign and magnitude, magnitude at most full scale
   always_comb begin
      neg = 1'b0;
      mag = '0;
      case (wave_sel_type'(waveform))
         WAVE_SINE: begin
            neg = quadrant[1];
            mag = QUARTER[idx];
         end
         WAVE_TRIANGLE: begin
            if (tri_t > fs_ext) begin
               neg = 1'b1;
               mag = SAMPLE_BITS'(tri_t - fs_ext);
            end else begin
               mag = SAMPLE_BITS'(fs_ext - tri_t);
            end
         end
         WAVE_SQUARE: begin
            neg = ~phase[PHASE_BITS-1];
            mag = FS;
         end
         WAVE_SAWTOOTH: begin
            mag = saw_mag;
         end
         default: begin
            mag = '0;
         end
      endcase
   end

   // round half away from zero, clamp positive full scale
   assign product = (SAMPLE_BITS+AMP_BITS)'(mag) * (SAMPLE_BITS+AMP_BITS)'(amplitude);
   assign rounded = (SAMPLE_BITS+AMP_BITS+1)'(product)
                    + (SAMPLE_BITS+AMP_BITS+1)'(1 << (AMP_BITS - 1));
   assign scaled  = rounded[AMP_BITS +: SAMPLE_BITS];
   assign pos_sat = (scaled > FS_MAX) ? FS_MAX : scaled;
   assign sample  = neg ? SAMPLE_BITS'(-scaled) : pos_sat;

endmodule

FILE: rtl/multi_waveform_phase_oscillator_core.sv
// Channel  | Ports                               | Direction
// ---------+-------------------------------------+----------
// request  | req_valid, req_stall, req_phase_reset | in
// response | rsp_valid, rsp_stall, rsp_sample      | out
// config   | csr_write_enable, csr_index, csr_wdata | in
//
// One transaction per clock sustained while the response is not stalled; a request passes
// through the phase register stage, then waveform lookup, gain multiply and rounding into
// the output register. The phase accumulator add sets the per-cycle recurrence.
// Reset (synchronous) clears phase to zero and loads default registers.
// A stalled response holds; the request side stalls only when both stages are full.
module multi_waveform_phase_oscillator_core
   import mwpo_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_phase_reset,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [TUNING_BITS-1:0] tuning_word_ff;
   logic [AMP_BITS-1:0]    amplitude_ff;
   logic [WAVE_BITS-1:0]   waveform_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_in;
   logic [SAMPLE_BITS-1:0] wave_sample;
   logic                   out_ready;
   logic                   req_accept;
   logic                   drain;
   stage_type              stage;

   always_ff @(posedge clock) begin
      if (reset) begin
         tuning_word_ff <= '0;
         amplitude_ff   <= '1;
         waveform_ff    <= WAVE_SINE;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_TUNING_WORD: tuning_word_ff <= csr_wdata[TUNING_BITS-1:0];
            CSR_AMPLITUDE:   amplitude_ff   <= csr_wdata[AMP_BITS-1:0];
            CSR_WAVEFORM:    waveform_ff    <= csr_wdata[WAVE_BITS-1:0];
            default: begin
               // drop writes to unmapped index
            end
         endcase
      end
   end

   assign out_ready  = ~rsp_valid_ff | ~rsp_stall;
   assign drain      = stage.valid & out_ready;
   assign req_stall  = stage.valid & ~out_ready;
   assign req_accept = req_valid & ~req_stall;

   mwpo_phase_acc u_phase_acc (
      .clock       (clock),
      .reset       (reset),
      .load        (req_accept),
      .phase_reset (req_phase_reset),
      .drain       (drain),
      .tuning_word (tuning_word_ff),
      .stage       (stage)
   );

   mwpo_wave_gen u_wave_gen (
      .phase     (stage.phase),
      .waveform  (waveform_ff),
      .amplitude (amplitude_ff),
      .sample    (wave_sample)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      if (out_ready) begin
         rsp_valid_in  = stage.valid;
         rsp_sample_in = wave_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = signed'(rsp_sample_ff);

   a_stall_needs_full_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage.valid)
      else $error("request stalled with empty phase stage");

   a_phase_reset_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_phase_reset) |=> (stage.phase == '0))
      else $error("phase not cleared by phase reset");

   a_stage_moves_out: assert property (@(posedge clock) disable iff (reset)
      (stage.valid && out_ready) |=> rsp_valid)
      else $error("stage transaction lost on the way to the output register");

endmodule
